[rtl/core/ttu_pkg.sv]
// ---------------------------------------------------------------------------
// Triangle tangent package
// Shared widths, word types and the controller-to-datapath command word.
// ---------------------------------------------------------------------------
package ttu_pkg;

   // Coordinate format: signed fixed point with FRAC_W fraction bits.
   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;

   // Derived datapath widths.
   localparam int DELTA_W = COORD_W + 1;          // difference of two coordinates
   localparam int PROD_W  = 2 * DELTA_W;          // exact product of two deltas
   localparam int ACC_W   = PROD_W + 1;           // difference of two products
   localparam int DVD_W   = ACC_W + FRAC_W;       // dividend after the fraction shift
   localparam int CNT_W   = $clog2(DVD_W);        // division step counter
   localparam int QUOT_W  = COORD_W + 2;          // kept quotient bits before saturation
   localparam int QR_W    = QUOT_W + 1;           // quotient after rounding

   // Saturation limits of the rounded quotient magnitude.
   localparam logic [QR_W-1:0] LIM_POS = QR_W'((64'd1 << (COORD_W - 1)) - 64'd1);
   localparam logic [QR_W-1:0] LIM_NEG = QR_W'(64'd1 << (COORD_W - 1));

   // Vertex phase codes within one triangle.
   localparam logic [1:0] PHASE_V0 = 2'd0;
   localparam logic [1:0] PHASE_V1 = 2'd1;
   localparam logic [1:0] PHASE_V2 = 2'd2;

   // Component selector codes: the determinant first, then x, y and z.
   localparam logic [1:0] COMP_DET = 2'd0;
   localparam logic [1:0] COMP_X   = 2'd1;
   localparam logic [1:0] COMP_Z   = 2'd3;

   // Input word: one vertex.
   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] tex_u;
      logic signed [COORD_W-1:0] tex_v;
      logic                      uv_present;
   } vertex_type;

   // Result word: one triangle tangent.
   typedef struct packed {
      logic signed [COORD_W-1:0] tangent_x;
      logic signed [COORD_W-1:0] tangent_y;
      logic signed [COORD_W-1:0] tangent_z;
      logic                      degenerate;
   } tangent_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       hold_we;     // store the vertex in a holding slot
      logic       hold_slot;   // holding slot: first or second vertex
      logic       work_clear;  // zero the working tangent and flag
      logic       delta_load;  // form edges and uv deltas from the third vertex
      logic       mul;         // register one product
      logic       mul_b;       // select the second product of the pair
      logic       acc_load;    // accumulator takes the first product
      logic       acc_sub;     // accumulator subtracts the second product
      logic       det_load;    // keep the accumulator as the determinant
      logic       set_degen;   // mark the triangle degenerate
      logic       div_init;    // prepare the divider from numerator and determinant
      logic       div_step;    // one restoring division step
      logic       round;       // round, saturate and store one component
      logic       out_load;    // copy the working result to the output register
      logic [1:0] comp;        // component being worked on
   } ttu_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic acc_zero;          // accumulator holds zero
   } ttu_status_type;

endpackage

[rtl/core/ttu_datapath.sv]
// ---------------------------------------------------------------------------
// Triangle tangent datapath
// Holding registers, delta formation, a shared multiplier with accumulator,
// a bit-serial restoring divider, and the rounding and output registers.
// ---------------------------------------------------------------------------
module ttu_datapath
   import ttu_pkg::*;
(
   input  logic           clock,
   input  ttu_cmd_type    cmd,
   input  vertex_type     vtx,
   output ttu_status_type status,
   output tangent_type    result
);

   // Holding registers for the first two vertices of a triangle.
   logic signed [COORD_W-1:0] hold_pos_ff [2][3];
   logic signed [COORD_W-1:0] hold_tex_ff [2][2];

   // Edge and uv delta registers.
   logic signed [DELTA_W-1:0] e1_ff [3];
   logic signed [DELTA_W-1:0] e2_ff [3];
   logic signed [DELTA_W-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;

   // Multiplier and accumulator.
   logic signed [DELTA_W-1:0] op_a, op_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   det_ff;

   // Divider state.
   logic [DVD_W-1:0]  dvd_ff;
   logic [ACC_W-1:0]  dvs_ff;
   logic [ACC_W-1:0]  rem_ff;
   logic [QUOT_W-1:0] quo_ff;
   logic              sticky_ff;
   logic              neg_ff;

   // Working result and output register.
   logic signed [COORD_W-1:0] tan_ff [3];
   logic                      degen_ff;
   tangent_type               out_ff;

   // Texture coordinates count as zero when the vertex carries none.
   logic signed [COORD_W-1:0] tex_u_in, tex_v_in;
   logic [1:0]                comp_idx;

   assign tex_u_in = vtx.uv_present ? vtx.tex_u : '0;
   assign tex_v_in = vtx.uv_present ? vtx.tex_v : '0;
   assign comp_idx = cmd.comp - 2'd1;

   // Holding registers.
   always_ff @(posedge clock) begin
      if (cmd.hold_we) begin
         hold_pos_ff[cmd.hold_slot][0] <= vtx.pos_x;
         hold_pos_ff[cmd.hold_slot][1] <= vtx.pos_y;
         hold_pos_ff[cmd.hold_slot][2] <= vtx.pos_z;
         hold_tex_ff[cmd.hold_slot][0] <= tex_u_in;
         hold_tex_ff[cmd.hold_slot][1] <= tex_v_in;
      end
   end

   // Edges and uv deltas, all relative to the first vertex.
   always_ff @(posedge clock) begin
      if (cmd.delta_load) begin
         e1_ff[0] <= DELTA_W'(hold_pos_ff[1][0]) - DELTA_W'(hold_pos_ff[0][0]);
         e1_ff[1] <= DELTA_W'(hold_pos_ff[1][1]) - DELTA_W'(hold_pos_ff[0][1]);
         e1_ff[2] <= DELTA_W'(hold_pos_ff[1][2]) - DELTA_W'(hold_pos_ff[0][2]);
         e2_ff[0] <= DELTA_W'(vtx.pos_x) - DELTA_W'(hold_pos_ff[0][0]);
         e2_ff[1] <= DELTA_W'(vtx.pos_y) - DELTA_W'(hold_pos_ff[0][1]);
         e2_ff[2] <= DELTA_W'(vtx.pos_z) - DELTA_W'(hold_pos_ff[0][2]);
         du1_ff   <= DELTA_W'(hold_tex_ff[1][0]) - DELTA_W'(hold_tex_ff[0][0]);
         dv1_ff   <= DELTA_W'(hold_tex_ff[1][1]) - DELTA_W'(hold_tex_ff[0][1]);
         du2_ff   <= DELTA_W'(tex_u_in) - DELTA_W'(hold_tex_ff[0][0]);
         dv2_ff   <= DELTA_W'(tex_v_in) - DELTA_W'(hold_tex_ff[0][1]);
      end
   end

   // Operand selection. The determinant is du1*dv2 - du2*dv1; each
   // numerator component is dv2*e1 - dv1*e2.
   always_comb begin
      if (cmd.comp == COMP_DET) begin
         op_a = cmd.mul_b ? du2_ff : du1_ff;
         op_b = cmd.mul_b ? dv1_ff : dv2_ff;
      end else begin
         op_a = cmd.mul_b ? dv1_ff : dv2_ff;
         op_b = cmd.mul_b ? e2_ff[comp_idx] : e1_ff[comp_idx];
      end
   end

   // Shared multiplier with its result register, then the accumulator.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
      end
      if (cmd.acc_load) begin
         acc_ff <= ACC_W'(prod_ff);
      end else if (cmd.acc_sub) begin
         acc_ff <= acc_ff - ACC_W'(prod_ff);
      end
      if (cmd.det_load) begin
         det_ff <= acc_ff;
      end
   end

   assign status.acc_zero = (acc_ff == '0);

   // Restoring division of |numerator| shifted by the fraction bits by
   // |determinant|, one quotient bit a cycle, most significant first.
   logic [ACC_W-1:0]  num_mag, det_mag;
   logic [ACC_W:0]    rem_shift, rem_diff;
   logic              rem_ge;

   assign num_mag   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign det_mag   = det_ff[ACC_W-1] ? ACC_W'(-det_ff) : ACC_W'(det_ff);
   assign rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, dvs_ff};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dvd_ff    <= {num_mag, FRAC_W'(0)};
         dvs_ff    <= det_mag;
         rem_ff    <= '0;
         quo_ff    <= '0;
         sticky_ff <= 1'b0;
         neg_ff    <= acc_ff[ACC_W-1] ^ det_ff[ACC_W-1];
      end else if (cmd.div_step) begin
         dvd_ff    <= {dvd_ff[DVD_W-2:0], 1'b0};
         rem_ff    <= rem_ge ? rem_diff[ACC_W-1:0] : rem_shift[ACC_W-1:0];
         quo_ff    <= {quo_ff[QUOT_W-2:0], rem_ge};
         sticky_ff <= sticky_ff | quo_ff[QUOT_W-1];
      end
   end

   // Round to nearest with ties away from zero, then saturate.
   logic              round_up;
   logic [QR_W-1:0]   quo_round, quo_lim, quo_mag;
   logic [COORD_W-1:0] comp_value;

   assign round_up   = {1'b0, rem_ff, 1'b0} >= {2'b00, dvs_ff};
   assign quo_round  = QR_W'(quo_ff) + QR_W'(round_up);
   assign quo_lim    = neg_ff ? LIM_NEG : LIM_POS;
   assign quo_mag    = (sticky_ff || (quo_round > quo_lim)) ? quo_lim : quo_round;
   assign comp_value = neg_ff ? COORD_W'(-quo_mag) : COORD_W'(quo_mag);

   // Working result registers.
   always_ff @(posedge clock) begin
      if (cmd.work_clear) begin
         tan_ff[0] <= '0;
         tan_ff[1] <= '0;
         tan_ff[2] <= '0;
         degen_ff  <= 1'b0;
      end else begin
         if (cmd.round) begin
            tan_ff[comp_idx] <= comp_value;
         end
         if (cmd.set_degen) begin
            degen_ff <= 1'b1;
         end
      end
   end

   // Output register: holds a finished word until it is taken.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.tangent_x  <= tan_ff[0];
         out_ff.tangent_y  <= tan_ff[1];
         out_ff.tangent_z  <= tan_ff[2];
         out_ff.degenerate <= degen_ff;
      end
   end

   assign result = out_ff;

endmodule

[rtl/core/ttu_ctrl.sv]
// ---------------------------------------------------------------------------
// Triangle tangent controller
// Vertex phase tracking, the control register, the sequencer that steps the
// datapath through products, division and rounding, and the output valid.
// ---------------------------------------------------------------------------
module ttu_ctrl
   import ttu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic           csr_wdata,
   input  ttu_status_type status,
   output ttu_cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_MULA  = 10'b00_0000_0010,
      ST_ACCA  = 10'b00_0000_0100,
      ST_MULB  = 10'b00_0000_1000,
      ST_ACCB  = 10'b00_0001_0000,
      ST_CHECK = 10'b00_0010_0000,
      ST_DINIT = 10'b00_0100_0000,
      ST_DIV   = 10'b00_1000_0000,
      ST_ROUND = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [1:0]       comp_ff, comp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             enable_ff, enable_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_fire, out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Control register.
   assign enable_in = (csr_valid && csr_ready) ? csr_wdata : enable_ff;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      comp_in      = comp_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.comp     = comp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (phase_ff == PHASE_V2) begin
                  phase_in       = PHASE_V0;
                  cmd.work_clear = 1'b1;
                  if (enable_ff) begin
                     cmd.delta_load = 1'b1;
                     comp_in        = COMP_DET;
                     state_in       = ST_MULA;
                  end else begin
                     state_in = ST_DONE;
                  end
               end else begin
                  // An unused phase code would be treated as the first vertex.
                  cmd.hold_we   = 1'b1;
                  cmd.hold_slot = (phase_ff == PHASE_V1);
                  phase_in      = (phase_ff == PHASE_V1) ? PHASE_V2 : PHASE_V1;
               end
            end
         end
         ST_MULA: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACCA;
         end
         ST_ACCA: begin
            cmd.acc_load = 1'b1;
            state_in     = ST_MULB;
         end
         ST_MULB: begin
            cmd.mul   = 1'b1;
            cmd.mul_b = 1'b1;
            state_in  = ST_ACCB;
         end
         ST_ACCB: begin
            cmd.acc_sub = 1'b1;
            state_in    = (comp_ff == COMP_DET) ? ST_CHECK : ST_DINIT;
         end
         ST_CHECK: begin
            // A zero determinant ends the triangle with a zero tangent.
            cmd.det_load = 1'b1;
            if (status.acc_zero) begin
               cmd.set_degen = 1'b1;
               state_in      = ST_DONE;
            end else begin
               comp_in  = COMP_X;
               state_in = ST_MULA;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = CNT_W'(DVD_W - 1);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_ROUND;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (comp_ff == COMP_Z) begin
               state_in = ST_DONE;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_MULA;
            end
         end
         ST_DONE: begin
            // Wait until the output register is free, then hand the word over.
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PHASE_V0;
         comp_ff      <= COMP_DET;
         cnt_ff       <= '0;
         enable_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         comp_ff      <= comp_in;
         cnt_ff       <= cnt_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/triangle_tangent_from_uv.sv]
// Sequence: the first and second vertex of a triangle go to holding registers; once the
// third is taken, the sequencer forms the determinant from a product pair and a zero
// check, then per component a product pair, a divider setup, the division steps and a
// rounding step, then hands the word over (directly with tangents off, after the check
// for a zero determinant). req_ready stays low until the hand-over, also in a result stall.
// Synchronous active-high reset clears phase, sequencer and output valid, sets enable to 1.
// ---------------------------------------------------------------------------
// Triangle tangent from texture coordinates
// Takes a triangle list one vertex word at a time and, on every third vertex,
// gives one saturated Q16.16 tangent shared by the whole triangle.
// ---------------------------------------------------------------------------
module triangle_tangent_from_uv
   import ttu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  vertex_type  req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tangent_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata
);

   ttu_cmd_type    cmd;
   ttu_status_type status;

   // Controller: phases, sequencing and handshakes.
   ttu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: arithmetic and result storage.
   ttu_datapath u_datapath (
      .clock  (clock),
      .cmd    (cmd),
      .vtx    (req_data),
      .status (status),
      .result (rsp_data)
   );

endmodule
